>>> src/alusf_pkg.sv
// alusf_pkg: command codes, status bit positions and reset value for the
// status-flag alu. No dependencies; imported by alu_with_status_flags.
`default_nettype none

package alusf_pkg;

  // operation codes carried on command_i
  typedef enum logic [3:0] {
    CMD_ORA  = 4'd0,
    CMD_AND  = 4'd1,
    CMD_EOR  = 4'd2,
    CMD_ADC  = 4'd3,
    CMD_SBC  = 4'd4,
    CMD_CMP  = 4'd5,
    CMD_BIT  = 4'd6,
    CMD_INC  = 4'd7,
    CMD_DEC  = 4'd8,
    CMD_ASL  = 4'd9,
    CMD_LSR  = 4'd10,
    CMD_ROL  = 4'd11,
    CMD_ROR  = 4'd12,
    CMD_PASS = 4'd13,
    CMD_PLP  = 4'd14,
    CMD_PLPB = 4'd15
  } cmd_e;

  // status byte bit positions
  localparam int unsigned FlagC = 0;
  localparam int unsigned FlagZ = 1;
  localparam int unsigned FlagB = 4;
  localparam int unsigned FlagV = 6;
  localparam int unsigned FlagN = 7;

  // only the unused bit is set out of reset
  localparam logic [7:0] StatusReset = 8'h20;

endpackage

`default_nettype wire

>>> src/alu_with_status_flags.sv
// alu_with_status_flags: binary-mode 8-bit alu holding the processor status
// byte, with an input register and a result register. Uses alusf_pkg.
//
//   channel | handshake                 | word
//   --------+---------------------------+-----------------------------------
//   in      | in_valid_i / in_ready_o   | command_i, reg_value_i, mem_value_i
//   out     | out_valid_o / out_ready_i | result_o, flag_*_o, status_byte_o
//
// One word per cycle sustained while out_ready_i stays high; an accepted word
// passes through the input register, then the result register.
// The status register updates as a word moves from the input register into
// the result register, so the next word sees the new carry.
// When the result is not taken the stages hold and fill; in_ready_o drops
// only when both stages are full and out_ready_i is low.
// rst_ni clears both stage valid bits and sets the status byte to 0x20.
`default_nettype none

module alu_with_status_flags (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire  [3:0]         command_i,
  input  wire  [7:0]         reg_value_i,
  input  wire  [7:0]         mem_value_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic [7:0]         result_o,
  output logic               flag_negative_o,
  output logic               flag_overflow_o,
  output logic               flag_zero_o,
  output logic               flag_carry_o,
  output logic [7:0]         status_byte_o
);
  import alusf_pkg::*;

  logic       in_valid_q;
  cmd_e       in_cmd_q;
  logic [7:0] in_reg_q;
  logic [7:0] in_mem_q;
  logic       out_valid_q;
  logic [7:0] out_result_q;
  logic [7:0] out_status_q;
  logic [7:0] status_q;
  logic [7:0] status_d;
  logic [7:0] result_d;
  logic       out_load;
  logic       move;

  // pipeline flow control
  assign out_load   = !out_valid_q || out_ready_i;
  assign move       = in_valid_q && out_load;
  assign in_ready_o = !in_valid_q || out_load;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_cmd_q <= cmd_e'(command_i);
      in_reg_q <= reg_value_i;
      in_mem_q <= mem_value_i;
    end
  end

  // operation and flag update
  logic [7:0] add_b;
  logic [8:0] sum;
  logic [8:0] diff;
  always_comb begin
    add_b    = (in_cmd_q == CMD_SBC) ? ~in_mem_q : in_mem_q;
    sum      = {1'b0, in_reg_q} + {1'b0, add_b} + {8'd0, status_q[FlagC]};
    diff     = {1'b0, in_reg_q} - {1'b0, in_mem_q};
    status_d = status_q;
    result_d = 8'd0;
    case (in_cmd_q)
      CMD_ORA: result_d = in_reg_q | in_mem_q;
      CMD_AND: result_d = in_reg_q & in_mem_q;
      CMD_EOR: result_d = in_reg_q ^ in_mem_q;
      CMD_ADC, CMD_SBC: begin
        result_d        = sum[7:0];
        status_d[FlagC] = sum[8];
        status_d[FlagV] = ~(in_reg_q[7] ^ add_b[7]) & (in_reg_q[7] ^ sum[7]);
      end
      CMD_CMP: begin
        result_d        = diff[7:0];
        status_d[FlagC] = !diff[8];
      end
      CMD_BIT: result_d = in_reg_q & in_mem_q;
      CMD_INC: result_d = in_reg_q + 8'd1;
      CMD_DEC: result_d = in_reg_q - 8'd1;
      CMD_ASL: begin
        result_d        = {in_reg_q[6:0], 1'b0};
        status_d[FlagC] = in_reg_q[7];
      end
      CMD_LSR: begin
        result_d        = {1'b0, in_reg_q[7:1]};
        status_d[FlagC] = in_reg_q[0];
      end
      CMD_ROL: begin
        result_d        = {in_reg_q[6:0], status_q[FlagC]};
        status_d[FlagC] = in_reg_q[7];
      end
      CMD_ROR: begin
        result_d        = {status_q[FlagC], in_reg_q[7:1]};
        status_d[FlagC] = in_reg_q[0];
      end
      CMD_PASS: result_d = in_mem_q;
      CMD_PLP: begin
        status_d = in_mem_q;
        result_d = in_mem_q;
      end
      CMD_PLPB: begin
        status_d        = in_mem_q;
        status_d[FlagB] = 1'b0;
        result_d        = status_d;
      end
      default: result_d = 8'd0;
    endcase

    // n and z: from the result, except n on bit test (memory bit 7) and both on status pull
    if (in_cmd_q == CMD_BIT) begin
      status_d[FlagN] = in_mem_q[7];
      status_d[FlagV] = in_mem_q[6];
      status_d[FlagZ] = (result_d == 8'd0);
    end else if (in_cmd_q != CMD_PLP && in_cmd_q != CMD_PLPB) begin
      status_d[FlagN] = result_d[7];
      status_d[FlagZ] = (result_d == 8'd0);
    end
  end

  // status register and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q    <= StatusReset;
      out_valid_q <= 1'b0;
    end else begin
      if (move) begin
        status_q <= status_d;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      out_result_q <= result_d;
      out_status_q <= status_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign result_o        = out_result_q;
  assign status_byte_o   = out_status_q;
  assign flag_negative_o = out_status_q[FlagN];
  assign flag_overflow_o = out_status_q[FlagV];
  assign flag_zero_o     = out_status_q[FlagZ];
  assign flag_carry_o    = out_status_q[FlagC];

`ifndef NO_ASSERTIONS
  // the word on the output always shows the live status register
  a_status_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_status_q == status_q))
    else $error("output status differs from status register");

  // a word held in the input stage is not lost while the output stalls
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !out_load) |=> (in_valid_q && $stable(in_reg_q)))
    else $error("input stage lost a stalled word");

  // only a status pull touches the b, d, i and unused bits
  a_hidden_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && in_cmd_q != CMD_PLP && in_cmd_q != CMD_PLPB)
      |=> (status_q[5:2] == $past(status_q[5:2])))
    else $error("hidden status bits changed outside a pull");

  // pull with clear break leaves b low
  a_break_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (move && in_cmd_q == CMD_PLPB) |=> !status_q[FlagB])
    else $error("break bit set after pull with clear");
`endif

endmodule

`default_nettype wire

>>> sim/tb_alu_with_status_flags.sv
// tb_alu_with_status_flags: self-checking bench for the status-flag alu, with a
// queue-fed driver, a checking monitor and an in-bench flag predictor.
// Depends on alusf_pkg and alu_with_status_flags from src.
`default_nettype none

module tb_alu_with_status_flags;
  import alusf_pkg::*;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] reg_val;
    logic [7:0] mem_val;
  } alu_word_t;

  typedef struct packed {
    logic [7:0] result;
    logic       neg;
    logic       ovf;
    logic       zero;
    logic       carry;
    logic [7:0] status;
  } alu_result_t;

  localparam int unsigned RandomWords = 850;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned CalmFirst   = 700;
  localparam int unsigned CalmLast    = 1000;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       in_valid_i    = 1'b0;
  logic [3:0] command_i     = 4'd0;
  logic [7:0] reg_value_i   = 8'd0;
  logic [7:0] mem_value_i   = 8'd0;
  logic       out_ready_i   = 1'b0;
  logic       in_ready_o;
  logic       out_valid_o;
  logic [7:0] result_o;
  logic       flag_negative_o;
  logic       flag_overflow_o;
  logic       flag_zero_o;
  logic       flag_carry_o;
  logic [7:0] status_byte_o;

  alu_word_t   pending_words[$];
  alu_result_t expected_results[$];
  alu_word_t   offered_word;
  logic [7:0]  psw_model = StatusReset;

  int unsigned words_sent      = 0;
  int unsigned total_words     = 0;
  int unsigned results_checked = 0;
  int unsigned fail_count      = 0;
  int unsigned cycle_count     = 0;
  int unsigned stall_cycles    = 0;
  int unsigned hold_left       = 0;
  bit          hold_done       = 1'b0;
  bit          calm;

  alu_with_status_flags dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .command_i      (command_i),
    .reg_value_i    (reg_value_i),
    .mem_value_i    (mem_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .result_o       (result_o),
    .flag_negative_o(flag_negative_o),
    .flag_overflow_o(flag_overflow_o),
    .flag_zero_o    (flag_zero_o),
    .flag_carry_o   (flag_carry_o),
    .status_byte_o  (status_byte_o)
  );

  // clock and reset
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  assign calm = (cycle_count >= CalmFirst) && (cycle_count <= CalmLast);

  // sets n and z in the predicted status from a byte
  function automatic void put_nz(logic [7:0] v);
    psw_model[FlagN] = v[7];
    psw_model[FlagZ] = (v == 8'h00);
  endfunction

  // binary add into the predicted status, returns the sum byte
  function automatic logic [7:0] add_bytes(logic [7:0] a, logic [7:0] b);
    logic [8:0] sum;
    sum = {1'b0, a} + {1'b0, b} + {8'd0, psw_model[FlagC]};
    psw_model[FlagV] = ~(a[7] ^ b[7]) & (a[7] ^ sum[7]);
    psw_model[FlagC] = sum[8];
    put_nz(sum[7:0]);
    return sum[7:0];
  endfunction

  // next result and status for one word, in acceptance order
  function automatic alu_result_t alu_predict(alu_word_t w);
    alu_result_t o;
    logic [7:0]  r;
    logic [7:0]  m;
    logic [7:0]  res;
    logic        old_c;
    r     = w.reg_val;
    m     = w.mem_val;
    old_c = psw_model[FlagC];
    res   = 8'h00;
    case (w.cmd)
      CMD_ORA: begin res = r | m; put_nz(res); end
      CMD_AND: begin res = r & m; put_nz(res); end
      CMD_EOR: begin res = r ^ m; put_nz(res); end
      CMD_ADC: res = add_bytes(r, m);
      CMD_SBC: res = add_bytes(r, ~m);
      CMD_CMP: begin
        res = r - m;
        psw_model[FlagC] = (r >= m);
        psw_model[FlagZ] = (r == m);
        psw_model[FlagN] = res[7];
      end
      CMD_BIT: begin
        res = r & m;
        psw_model[FlagZ] = (res == 8'h00);
        psw_model[FlagN] = m[7];
        psw_model[FlagV] = m[6];
      end
      CMD_INC: begin res = r + 8'd1; put_nz(res); end
      CMD_DEC: begin res = r - 8'd1; put_nz(res); end
      CMD_ASL: begin psw_model[FlagC] = r[7]; res = {r[6:0], 1'b0}; put_nz(res); end
      CMD_LSR: begin psw_model[FlagC] = r[0]; res = {1'b0, r[7:1]}; put_nz(res); end
      CMD_ROL: begin psw_model[FlagC] = r[7]; res = {r[6:0], old_c}; put_nz(res); end
      CMD_ROR: begin psw_model[FlagC] = r[0]; res = {old_c, r[7:1]}; put_nz(res); end
      CMD_PASS: begin res = m; put_nz(res); end
      CMD_PLP: begin psw_model = m; res = psw_model; end
      default: begin
        psw_model = m;
        psw_model[FlagB] = 1'b0;
        res = psw_model;
      end
    endcase
    o.result = res;
    o.neg    = psw_model[FlagN];
    o.ovf    = psw_model[FlagV];
    o.zero   = psw_model[FlagZ];
    o.carry  = psw_model[FlagC];
    o.status = psw_model;
    return o;
  endfunction

  function automatic void add_word(cmd_e c, logic [7:0] r, logic [7:0] m);
    alu_word_t w;
    w.cmd     = c;
    w.reg_val = r;
    w.mem_val = m;
    pending_words.push_back(w);
  endfunction

  // operand byte, leaning on the corner values now and then
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h80;
      3: return 8'h7f;
      4: return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // stimulus: directed corners, then random words, then drain and report
  initial begin
    add_word(CMD_ORA, 8'h00, 8'h00);
    add_word(CMD_AND, 8'hff, 8'hff);
    add_word(CMD_EOR, 8'hff, 8'hff);
    add_word(CMD_PLPB, 8'h00, 8'hff);      // all flags set, break cleared, decimal on
    add_word(CMD_ADC, 8'h7f, 8'h00);       // carry in, signed overflow, decimal ignored
    add_word(CMD_ADC, 8'hff, 8'h01);
    add_word(CMD_SBC, 8'h80, 8'h01);
    add_word(CMD_SBC, 8'h00, 8'h00);
    add_word(CMD_CMP, 8'h42, 8'h42);
    add_word(CMD_CMP, 8'h00, 8'hff);
    add_word(CMD_CMP, 8'hff, 8'h00);
    add_word(CMD_BIT, 8'h00, 8'hc0);
    add_word(CMD_BIT, 8'hff, 8'h3f);
    add_word(CMD_INC, 8'hff, 8'h00);
    add_word(CMD_DEC, 8'h00, 8'h00);
    add_word(CMD_ASL, 8'h80, 8'h00);
    add_word(CMD_LSR, 8'h01, 8'h00);
    add_word(CMD_ROL, 8'h80, 8'h00);
    add_word(CMD_ROR, 8'h01, 8'h00);
    add_word(CMD_ROR, 8'h00, 8'h00);
    add_word(CMD_PASS, 8'h00, 8'h80);
    add_word(CMD_PASS, 8'hff, 8'h00);
    add_word(CMD_PLP, 8'h00, 8'h00);
    add_word(CMD_PLP, 8'h00, 8'hff);
    add_word(CMD_ADC, 8'h80, 8'h80);
    for (int i = 0; i < RandomWords; i++) begin
      add_word(cmd_e'($urandom_range(0, 15)), pick_byte(), pick_byte());
    end
    total_words = pending_words.size();

    // wait until every word is taken and every result checked
    @(posedge rst_ni);
    while (words_sent != total_words || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (6) @(posedge clk_i);

    $display("run: %0d words sent, %0d results checked over all 16 commands,",
             words_sent, results_checked);
    $display("     random gaps on both sides plus a %0d-cycle output hold-off", HoldCycles);
    if (fail_count == 0) begin
      $display("PASS alu_with_status_flags");
    end else begin
      $display("FAIL alu_with_status_flags");
    end
    $finish;
  end

  // driver: offers the next word, holds it until taken
  always @(posedge clk_i) begin
    logic next_valid;
    if (rst_ni) begin
      next_valid = in_valid_i;
      if (in_valid_i && in_ready_o) begin
        expected_results.push_back(alu_predict(offered_word));
        words_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_words.size() != 0 &&
          (calm || $urandom_range(0, 99) >= 24)) begin
        offered_word = pending_words.pop_front();
        next_valid   = 1'b1;
        command_i   <= offered_word.cmd;
        reg_value_i <= offered_word.reg_val;
        mem_value_i <= offered_word.mem_val;
      end
      in_valid_i <= next_valid;
    end
  end

  // monitor: checks each taken word and paces out_ready_i
  always @(posedge clk_i) begin
    alu_result_t exp_r;
    logic        next_ready;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_checked++;
        if (expected_results.size() == 0) begin
          $error("result word 0x%0h arrived with nothing expected", result_o);
          fail_count++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("result", exp_r.result, result_o);
          check_field("flag_negative", exp_r.neg, flag_negative_o);
          check_field("flag_overflow", exp_r.ovf, flag_overflow_o);
          check_field("flag_zero", exp_r.zero, flag_zero_o);
          check_field("flag_carry", exp_r.carry, flag_carry_o);
          check_field("status_byte", exp_r.status, status_byte_o);
        end
      end
      // one long hold-off so the pipe fills and in_ready_o drops
      if (hold_left != 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (!hold_done && results_checked >= 120) begin
        hold_done  = 1'b1;
        hold_left  = HoldCycles - 1;
        next_ready = 1'b0;
      end else begin
        next_ready = calm || ($urandom_range(0, 99) >= 24);
      end
      out_ready_i <= next_ready;
    end
  end

  // watchdog on cycles with no word moving on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count++;
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= StallLimit) begin
        $display("timeout: no word moved for %0d cycles", StallLimit);
        $display("FAIL alu_with_status_flags");
        $finish;
      end
    end
  end

endmodule

`default_nettype wire

>>> filelist.f
src/alusf_pkg.sv
src/alu_with_status_flags.sv
sim/tb_alu_with_status_flags.sv
